>>> rtl/core/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray/box slab intersect unit.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int unsigned Q_W        = 32;   // Q16.16 word
    localparam int unsigned NUM_W      = 33;   // exact difference width
    localparam int unsigned FRAC_W     = 16;
    localparam int unsigned DIV_STEPS  = 32;   // one quotient bit per stage
    localparam int unsigned DIV_LAT    = DIV_STEPS + 2;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

    localparam logic signed [Q_W-1:0] Q_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN      = 32'sh8000_0000;
    localparam logic signed [Q_W-1:0] EPS_RAW    = 32'sd66;       // 0.001
    localparam logic [15:0]           SCALE_FRAC = 16'd42950;     // 1.00001 - 1, 2^-32
    localparam logic signed [Q_W-1:0] BOX_MIN_RST = 32'sd0;
    localparam logic signed [Q_W-1:0] BOX_MAX_RST = 32'sd65536;

    // special cases of one division, carried along the divider stages
    typedef struct packed {
        logic neg;      // quotient negative
        logic ovf;      // magnitude beyond Q16.16 range
        logic dz;       // divide by zero
        logic num_pos;
        logic num_neg;
    } div_flags_t;

endpackage

>>> rtl/core/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined saturating Q16.16 divider: (num << 16) / den, truncated toward
// zero, one quotient bit per stage, one request per cycle while en is high.
// ----------------------------------------------------------------------------
module rbsi_div (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [rbsi_pkg::NUM_W-1:0]  num,
    input  logic signed [rbsi_pkg::Q_W-1:0]    den,
    output logic signed [rbsi_pkg::Q_W-1:0]    quo
);

    localparam int unsigned S = rbsi_pkg::DIV_STEPS;

    // front stage: magnitudes and range check
    logic [32:0] nmag;
    logic [48:0] nfull;
    logic [31:0] dmag;
    logic [63:0] dsh;
    logic [63:0] lim;
    rbsi_pkg::div_flags_t f_next;

    always_comb begin
        nmag  = num[32] ? (~num + 33'd1) : num;
        nfull = {nmag, 16'd0};
        dmag  = den[31] ? (~den + 32'd1) : den;
        dsh   = {1'b0, dmag, 31'd0};
        f_next.dz      = (den == '0);
        f_next.num_pos = !num[32] && (num != '0);
        f_next.num_neg = num[32];
        f_next.neg     = num[32] ^ den[31];
        lim            = f_next.neg ? (dsh + {32'd0, dmag}) : dsh;
        f_next.ovf     = ({15'd0, nfull} >= lim);
    end

    logic [31:0]          rem_reg [0:S];
    logic [31:0]          nlo_reg [0:S];
    logic [31:0]          q_reg   [0:S];
    logic [31:0]          d_reg   [0:S];
    rbsi_pkg::div_flags_t f_reg   [0:S];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {15'd0, nfull[48:32]};
            nlo_reg[0] <= nfull[31:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= dmag;
            f_reg[0]   <= f_next;
        end
    end

    for (genvar i = 0; i < S; i++) begin : g_step
        logic [32:0] trial;
        logic [32:0] diff;
        logic        take;
        always_comb begin
            trial = {rem_reg[i], nlo_reg[i][31]};
            diff  = trial - {1'b0, d_reg[i]};
            take  = (trial >= {1'b0, d_reg[i]});
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1] <= take ? diff[31:0] : trial[31:0];
                nlo_reg[i+1] <= {nlo_reg[i][30:0], 1'b0};
                q_reg[i+1]   <= {q_reg[i][30:0], take};
                d_reg[i+1]   <= d_reg[i];
                f_reg[i+1]   <= f_reg[i];
            end
        end
    end

    // back stage: sign and saturation
    logic signed [31:0] quo_next;
    logic signed [31:0] quo_reg;

    always_comb begin
        if (f_reg[S].dz) begin
            quo_next = f_reg[S].num_pos ? rbsi_pkg::Q_MAX :
                       f_reg[S].num_neg ? rbsi_pkg::Q_MIN : '0;
        end else if (f_reg[S].ovf) begin
            quo_next = f_reg[S].neg ? rbsi_pkg::Q_MIN : rbsi_pkg::Q_MAX;
        end else begin
            quo_next = f_reg[S].neg ? -$signed(q_reg[S]) : $signed(q_reg[S]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

>>> rtl/core/ray_box_slab_intersect_unit.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_unit
// Slab test of a Q16.16 ray against the configured axis-aligned box.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_      | in  | s_tvalid/s_tready  | ray: origin xyz, dir xyz (192 bits)
//  m_      | out | m_tvalid/m_tready  | hit, hit_distance (40 bits)
//  cfg_    | in  | cfg_wr_en          | box corners, index 0..5
//
//  One ray request per cycle unless m_ stalls; each request passes the
//  six bit-per-stage dividers (32 quotient stages plus front and back).
//  Reset (aresetn low, synchronous) clears all valid bits and loads the
//  unit box. A stall at m_ freezes every stage at once; s_tready is low
//  only while a finished result waits and the output is not taken.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
    input  logic [191:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // hit [0], hit_distance [32:1], zero pad [39:33]
    output logic [39:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    localparam int unsigned LAT = rbsi_pkg::DIV_LAT;

    // box registers
    logic signed [31:0] lo_reg [0:2];
    logic signed [31:0] hi_reg [0:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                lo_reg[a] <= rbsi_pkg::BOX_MIN_RST;
                hi_reg[a] <= rbsi_pkg::BOX_MAX_RST;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                rbsi_pkg::REG_BOX_MIN_X: lo_reg[0] <= cfg_wdata;
                rbsi_pkg::REG_BOX_MIN_Y: lo_reg[1] <= cfg_wdata;
                rbsi_pkg::REG_BOX_MIN_Z: lo_reg[2] <= cfg_wdata;
                rbsi_pkg::REG_BOX_MAX_X: hi_reg[0] <= cfg_wdata;
                rbsi_pkg::REG_BOX_MAX_Y: hi_reg[1] <= cfg_wdata;
                rbsi_pkg::REG_BOX_MAX_Z: hi_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // global advance: whole pipe moves unless the output is held
    logic m_tvalid_reg;
    logic en;
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    // slab quotients: index a*2 = min plane (lo), a*2+1 = max plane (hi)
    logic signed [31:0] q [0:5];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [31:0] org;
        logic signed [31:0] dir;
        logic signed [32:0] num_lo;
        logic signed [32:0] num_hi;
        assign org    = s_tdata[a*32 +: 32];
        assign dir    = s_tdata[96 + a*32 +: 32];
        assign num_lo = {lo_reg[a][31], lo_reg[a]} - {org[31], org};
        assign num_hi = {hi_reg[a][31], hi_reg[a]} - {org[31], org};

        rbsi_div u_div_lo (
            .aclk (aclk),
            .en   (en),
            .num  (num_lo),
            .den  (dir),
            .quo  (q[a*2])
        );
        rbsi_div u_div_hi (
            .aclk (aclk),
            .en   (en),
            .num  (num_hi),
            .den  (dir),
            .quo  (q[a*2+1])
        );
    end

    // valid bits alongside the dividers
    logic [LAT-1:0] vdiv_reg;
    logic           v1_reg, v2_reg, v3_reg, v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vdiv_reg     <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vdiv_reg     <= {vdiv_reg[LAT-2:0], s_tvalid};
            v1_reg       <= vdiv_reg[LAT-1];
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            m_tvalid_reg <= v4_reg;
        end
    end

    // stage 1: order each slab pair
    logic signed [31:0] near_reg [0:2];
    logic signed [31:0] far_reg  [0:2];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                if (q[a*2] > q[a*2+1]) begin
                    near_reg[a] <= q[a*2+1];
                    far_reg[a]  <= q[a*2];
                end else begin
                    near_reg[a] <= q[a*2];
                    far_reg[a]  <= q[a*2+1];
                end
            end
        end
    end

    // stage 2: disjointness and interval merge
    logic signed [31:0] txy_min, txy_max, tmin_next, tmax_next;
    logic               miss_next;
    logic signed [31:0] tmin_reg, tmax_reg;
    logic               miss_reg;

    always_comb begin
        txy_min   = (near_reg[0] > near_reg[1]) ? near_reg[0] : near_reg[1];
        txy_max   = (far_reg[0] < far_reg[1]) ? far_reg[0] : far_reg[1];
        miss_next = (near_reg[0] > far_reg[1]) || (near_reg[1] > far_reg[0])
                 || (txy_min > far_reg[2]) || (near_reg[2] > txy_max);
        tmin_next = (near_reg[2] > txy_min) ? near_reg[2] : txy_min;
        tmax_next = (far_reg[2] < txy_max) ? far_reg[2] : txy_max;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tmin_reg <= tmin_next;
            tmax_reg <= tmax_next;
            miss_reg <= miss_next;
        end
    end

    // stage 3: pick distance, epsilon test
    logic signed [31:0] d_next;
    logic [30:0]        d_reg;
    logic               hit3_reg;

    always_comb begin
        if (tmin_reg < tmax_reg) begin
            d_next = tmin_reg;
        end else if (tmax_reg < tmin_reg) begin
            d_next = tmax_reg;
        end else begin
            d_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg    <= d_next[30:0];
            hit3_reg <= !miss_reg && (d_next >= rbsi_pkg::EPS_RAW);
        end
    end

    // stage 4: scale fraction product (d is positive on a hit)
    logic [46:0] prod_reg;
    logic [30:0] d4_reg;
    logic        hit4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= d_reg * rbsi_pkg::SCALE_FRAC;
            d4_reg   <= d_reg;
            hit4_reg <= hit3_reg;
        end
    end

    // stage 5: round, add, saturate into the output register
    logic [47:0] rnd;
    logic [32:0] sum;
    logic [31:0] dist_next;
    logic [31:0] dist_reg;
    logic        hit_reg;

    always_comb begin
        rnd       = {1'b0, prod_reg} + 48'h0000_8000_0000;
        sum       = {2'b00, d4_reg} + {17'd0, rnd[47:32]};
        dist_next = (sum[32:31] != 2'b00) ? rbsi_pkg::Q_MAX : sum[31:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg  <= hit4_reg;
            dist_reg <= hit4_reg ? dist_next : 32'd0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, dist_reg, hit_reg};

endmodule
